// File: rtl/core/v3a_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package v3a_pkg;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_NEG   = 4'd2,
    OP_MUL   = 4'd3,
    OP_SCALE = 4'd4,
    OP_DIV   = 4'd5,
    OP_SDIV  = 4'd6,
    OP_MAX   = 4'd7,
    OP_MAG   = 4'd8,
    OP_NORM  = 4'd9,
    OP_CROSS = 4'd10,
    OP_DOT   = 4'd11,
    OP_DIST  = 4'd12
  } opcode_t;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] scalar_in;
  } req_t;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] scalar_out;
    logic               div_zero;
    logic               overflowed;
  } rsp_t;

  typedef struct packed {
    logic dz;
    logic ov;
  } flags_t;

endpackage

`default_nettype wire

// File: rtl/core/vec3_fixed_point_alu.sv
// Fixed point 3D vector unit: add, subtract, negate, per-component multiply,
// scale, per-component and scalar divide, largest component, magnitude,
// normalize, cross and dot product and distance on signed Q(WORD_BITS-
// FRAC_BITS).FRAC_BITS operands. Three component lanes work side by side and
// a merge stage forms dot sums and squared lengths. One item is accepted
// every cycle while the output is not stalled. The depth is set mostly by the
// square root pipeline (one root bit per stage, WORD_BITS stages) followed by
// the divider pipelines (one quotient bit per stage, WORD_BITS + FRAC_BITS
// stages). Every operation runs the full depth.
// The whole pipeline holds while a result waits under stall.
`timescale 1ns / 1ps
`default_nettype none

module vec3_fixed_point_alu #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  v3a_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output v3a_pkg::rsp_t rsp
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;
  localparam int SW  = PW - F;
  localparam int DW  = SW + 2;
  localparam int DVL = W + F + 2;
  localparam int L   = W + DVL + 6;
  localparam int C1  = 4 + 8 * W;
  localparam int C2  = 4 + 11 * W + 2;
  localparam int C3  = 4 + 4 * W + 1;
  localparam logic signed [W-1:0] WMAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMINV = {1'b1, {(W-1){1'b0}}};

  logic [L-1:0] vld;
  logic         en;

  assign en        = !(vld[L-1] && rsp_stall);
  assign req_stall = !en;
  assign rsp_valid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], req_valid};
    end
  end

  // operand capture
  logic signed [W-1:0] a_in [3];
  logic signed [W-1:0] b_in [3];
  logic signed [W-1:0] k_in;

  if (W <= 32) begin : g_narrow
    assign a_in[0] = req.ax[W-1:0];
    assign a_in[1] = req.ay[W-1:0];
    assign a_in[2] = req.az[W-1:0];
    assign b_in[0] = req.bx[W-1:0];
    assign b_in[1] = req.by[W-1:0];
    assign b_in[2] = req.bz[W-1:0];
    assign k_in    = req.scalar_in[W-1:0];
  end else begin : g_wide
    assign a_in[0] = W'(req.ax);
    assign a_in[1] = W'(req.ay);
    assign a_in[2] = W'(req.az);
    assign b_in[0] = W'(req.bx);
    assign b_in[1] = W'(req.by);
    assign b_in[2] = W'(req.bz);
    assign k_in    = W'(req.scalar_in);
  end

  logic [3:0]          op0;
  logic signed [W-1:0] a0 [3];
  logic signed [W-1:0] b0 [3];
  logic signed [W-1:0] k0;
  logic signed [W-1:0] mx0;

  always_ff @(posedge clk) begin
    if (en) begin
      op0 <= req.opcode;
      a0  <= a_in;
      b0  <= b_in;
      k0  <= k_in;
    end
  end

  always_comb begin
    mx0 = a0[0];
    if (a0[1] > mx0) mx0 = a0[1];
    if (a0[2] > mx0) mx0 = a0[2];
  end

  // component lanes
  logic signed [W-1:0]  vres3 [3];
  logic                 vov3  [3];
  logic signed [SW-1:0] dsh3  [3];
  logic [PW-1:0]        sq3   [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3a_lane #(.W(W), .F(F)) u_lane (
      .clk  (clk),
      .en   (en),
      .op   (op0),
      .a    (a0[i]),
      .b    (b0[i]),
      .k    (k0),
      .ap   (a0[(i+1)%3]),
      .bp   (b0[(i+1)%3]),
      .aq   (a0[(i+2)%3]),
      .bq   (b0[(i+2)%3]),
      .vres (vres3[i]),
      .vov  (vov3[i]),
      .dsh  (dsh3[i]),
      .sq   (sq3[i])
    );
  end

  logic [3:0]          op3;
  logic signed [W-1:0] a3 [3];
  logic signed [W-1:0] b3 [3];
  logic signed [W-1:0] k3, mx3;
  logic [C1-1:0]       d1_out;

  v3a_delay #(.WIDTH(C1), .DEPTH(3)) u_d1 (
    .clk (clk),
    .en  (en),
    .d   ({op0, a0[0], a0[1], a0[2], b0[0], b0[1], b0[2], k0, mx0}),
    .q   (d1_out)
  );

  assign {op3, a3[0], a3[1], a3[2], b3[0], b3[1], b3[2], k3, mx3} = d1_out;

  // merge: dot sum and squared length
  logic signed [DW-1:0] dot_sum;
  logic                 dot_fit;
  logic signed [W-1:0]  dot_sat, sval_n;

  always_comb begin
    dot_sum = {{2{dsh3[0][SW-1]}}, dsh3[0]} + {{2{dsh3[1][SW-1]}}, dsh3[1]}
            + {{2{dsh3[2][SW-1]}}, dsh3[2]};
    dot_fit = (&dot_sum[DW-1:W-1]) || !(|dot_sum[DW-1:W-1]);
    dot_sat = dot_fit ? dot_sum[W-1:0] : (dot_sum[DW-1] ? WMINV : WMAXV);
    case (op3)
      v3a_pkg::OP_MAX: sval_n = mx3;
      v3a_pkg::OP_DOT: sval_n = dot_sat;
      default:         sval_n = '0;
    endcase
  end

  logic [3:0]          op4;
  logic signed [W-1:0] a4 [3];
  logic signed [W-1:0] b4 [3];
  logic signed [W-1:0] k4, sval4;
  logic signed [W-1:0] vres4 [3];
  logic                vov4, sov4;
  logic [PW-1:0]       sqsum4;

  always_ff @(posedge clk) begin
    if (en) begin
      op4    <= op3;
      a4     <= a3;
      b4     <= b3;
      k4     <= k3;
      vres4  <= vres3;
      vov4   <= vov3[0] | vov3[1] | vov3[2];
      sval4  <= sval_n;
      sov4   <= (op3 == v3a_pkg::OP_DOT) && !dot_fit;
      sqsum4 <= sq3[0] + sq3[1] + sq3[2];
    end
  end

  logic [W-1:0] root5;

  v3a_sqrt #(.W(W)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .n    (sqsum4),
    .root (root5)
  );

  logic [3:0]          op5;
  logic signed [W-1:0] a5 [3];
  logic signed [W-1:0] b5 [3];
  logic signed [W-1:0] k5, sval5;
  logic signed [W-1:0] vres5 [3];
  logic                vov5, sov5;
  logic [C2-1:0]       d2_out;

  v3a_delay #(.WIDTH(C2), .DEPTH(W)) u_d2 (
    .clk (clk),
    .en  (en),
    .d   ({op4, a4[0], a4[1], a4[2], b4[0], b4[1], b4[2], k4,
           vres4[0], vres4[1], vres4[2], vov4, sval4, sov4}),
    .q   (d2_out)
  );

  assign {op5, a5[0], a5[1], a5[2], b5[0], b5[1], b5[2], k5,
          vres5[0], vres5[1], vres5[2], vov5, sval5, sov5} = d2_out;

  // magnitude, then the dividers
  logic signed [W-1:0] msat, sval5n;
  logic                mov, is_mag, ov5n;
  logic signed [W-1:0] den5 [3];

  always_comb begin
    mov    = root5[W-1];
    msat   = mov ? WMAXV : root5;
    is_mag = (op5 == v3a_pkg::OP_MAG) || (op5 == v3a_pkg::OP_DIST);
    sval5n = is_mag ? msat : sval5;
    ov5n   = vov5 | sov5 | ((is_mag || (op5 == v3a_pkg::OP_NORM)) && mov);
    for (int i = 0; i < 3; i++) begin
      case (op5)
        v3a_pkg::OP_DIV:  den5[i] = b5[i];
        v3a_pkg::OP_SDIV: den5[i] = k5;
        default:          den5[i] = msat;
      endcase
    end
  end

  logic signed [W-1:0] q6  [3];
  v3a_pkg::flags_t     fl6 [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3a_div #(.W(W), .F(F)) u_div (
      .clk   (clk),
      .en    (en),
      .num   (a5[i]),
      .den   (den5[i]),
      .q     (q6[i]),
      .flags (fl6[i])
    );
  end

  logic [3:0]          op6;
  logic signed [W-1:0] vres6 [3];
  logic signed [W-1:0] sval6;
  logic                ov6;
  logic [C3-1:0]       d3_out;

  v3a_delay #(.WIDTH(C3), .DEPTH(DVL)) u_d3 (
    .clk (clk),
    .en  (en),
    .d   ({op5, vres5[0], vres5[1], vres5[2], sval5n, ov5n}),
    .q   (d3_out)
  );

  assign {op6, vres6[0], vres6[1], vres6[2], sval6, ov6} = d3_out;

  // result assembly
  logic                is_div;
  logic signed [W-1:0] r6 [3];

  always_comb begin
    is_div = (op6 == v3a_pkg::OP_DIV) || (op6 == v3a_pkg::OP_SDIV)
          || (op6 == v3a_pkg::OP_NORM);
    for (int i = 0; i < 3; i++) begin
      r6[i] = is_div ? q6[i] : vres6[i];
    end
  end

  logic [3:0] op_o;

  always_ff @(posedge clk) begin
    if (en) begin
      op_o           <= op6;
      rsp.rx         <= 32'(r6[0]);
      rsp.ry         <= 32'(r6[1]);
      rsp.rz         <= 32'(r6[2]);
      rsp.scalar_out <= 32'(sval6);
      rsp.div_zero   <= is_div && (fl6[0].dz || fl6[1].dz || fl6[2].dz);
      rsp.overflowed <= ov6 || (is_div && (fl6[0].ov || fl6[1].ov || fl6[2].ov));
    end
  end

  a_dz_only_div: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.div_zero |->
      (op_o == v3a_pkg::OP_DIV) || (op_o == v3a_pkg::OP_SDIV) ||
      (op_o == v3a_pkg::OP_NORM))
    else $error("div_zero on a non-divide item");

  a_scalar_ops_no_vec: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && ((op_o == v3a_pkg::OP_MAX) || (op_o == v3a_pkg::OP_MAG) ||
                  (op_o == v3a_pkg::OP_DOT) || (op_o == v3a_pkg::OP_DIST)) |->
      (rsp.rx == '0) && (rsp.ry == '0) && (rsp.rz == '0))
    else $error("vector result on a scalar item");

  a_vec_ops_no_scalar: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !((op_o == v3a_pkg::OP_MAX) || (op_o == v3a_pkg::OP_MAG) ||
                   (op_o == v3a_pkg::OP_DOT) || (op_o == v3a_pkg::OP_DIST)) |->
      (rsp.scalar_out == '0))
    else $error("scalar result on a vector item");

  a_mag_nonneg: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && ((op_o == v3a_pkg::OP_MAG) || (op_o == v3a_pkg::OP_DIST)) |->
      !rsp.scalar_out[31])
    else $error("negative magnitude");

  a_hold_frozen: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(vld))
    else $error("pipeline moved under stall");

endmodule

`default_nettype wire

// File: rtl/core/v3a_delay.sv
`timescale 1ns / 1ps
`default_nettype none

module v3a_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

`default_nettype wire

// File: rtl/core/v3a_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module v3a_lane #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [3:0]              op,
  input  logic signed [W-1:0]     a,
  input  logic signed [W-1:0]     b,
  input  logic signed [W-1:0]     k,
  input  logic signed [W-1:0]     ap,
  input  logic signed [W-1:0]     bp,
  input  logic signed [W-1:0]     aq,
  input  logic signed [W-1:0]     bq,
  output logic signed [W-1:0]     vres,
  output logic                    vov,
  output logic signed [2*W-F-1:0] dsh,
  output logic [2*W-1:0]          sq
);

  localparam int PW = 2 * W;
  localparam int SW = PW - F;
  localparam logic signed [W-1:0] WMAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMINV = {1'b1, {(W-1){1'b0}}};

  // first stage: add, subtract, negate and operand choice
  logic signed [W:0]   s_add, s_sub, s_neg, lin_w;
  logic signed [W-1:0] lin_n, x0_n, y0_n, x1_n, y1_n;
  logic                lin_fit;

  logic [3:0]          op1;
  logic signed [W-1:0] lin1, x0, y0, x1, y1;
  logic                lin_ov1;

  always_comb begin
    s_add = {a[W-1], a} + {b[W-1], b};
    s_sub = {a[W-1], a} - {b[W-1], b};
    s_neg = -{a[W-1], a};
    case (op)
      v3a_pkg::OP_ADD:  lin_w = s_add;
      v3a_pkg::OP_SUB:  lin_w = s_sub;
      v3a_pkg::OP_DIST: lin_w = s_sub;
      v3a_pkg::OP_NEG:  lin_w = s_neg;
      default:          lin_w = '0;
    endcase
    lin_fit = (lin_w[W] == lin_w[W-1]);
    lin_n   = lin_fit ? lin_w[W-1:0] : (lin_w[W] ? WMINV : WMAXV);
    x0_n = '0;
    y0_n = '0;
    x1_n = '0;
    y1_n = '0;
    case (op)
      v3a_pkg::OP_MUL,
      v3a_pkg::OP_DOT: begin
        x0_n = a;
        y0_n = b;
      end
      v3a_pkg::OP_SCALE: begin
        x0_n = a;
        y0_n = k;
      end
      v3a_pkg::OP_MAG,
      v3a_pkg::OP_NORM: begin
        x0_n = a;
        y0_n = a;
      end
      v3a_pkg::OP_CROSS: begin
        x0_n = ap;
        y0_n = bq;
        x1_n = aq;
        y1_n = bp;
      end
      default: begin
        x0_n = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1     <= op;
      lin1    <= lin_n;
      lin_ov1 <= !lin_fit;
      x0      <= x0_n;
      y0      <= y0_n;
      x1      <= x1_n;
      y1      <= y1_n;
    end
  end

  // second stage: products
  logic signed [W-1:0]  mx0, my0;
  logic signed [PW-1:0] p0, p1;
  logic [3:0]           op2;
  logic signed [W-1:0]  lin2;
  logic                 lin_ov2;

  assign mx0 = (op1 == v3a_pkg::OP_DIST) ? lin1 : x0;
  assign my0 = (op1 == v3a_pkg::OP_DIST) ? lin1 : y0;

  always_ff @(posedge clk) begin
    if (en) begin
      p0      <= mx0 * my0;
      p1      <= x1 * y1;
      op2     <= op1;
      lin2    <= lin1;
      lin_ov2 <= lin_ov1;
    end
  end

  // third stage: floor shift and saturation
  logic signed [SW-1:0] sh0, sh1;
  logic signed [SW:0]   diff;
  logic                 sh_fit, diff_fit;
  logic signed [W-1:0]  sh_sat, diff_sat, res_n;
  logic                 ov_n;

  always_comb begin
    sh0      = p0[PW-1:F];
    sh1      = p1[PW-1:F];
    diff     = {sh0[SW-1], sh0} - {sh1[SW-1], sh1};
    sh_fit   = (&sh0[SW-1:W-1]) || !(|sh0[SW-1:W-1]);
    diff_fit = (&diff[SW:W-1]) || !(|diff[SW:W-1]);
    sh_sat   = sh_fit ? sh0[W-1:0] : (sh0[SW-1] ? WMINV : WMAXV);
    diff_sat = diff_fit ? diff[W-1:0] : (diff[SW] ? WMINV : WMAXV);
    case (op2)
      v3a_pkg::OP_ADD,
      v3a_pkg::OP_SUB,
      v3a_pkg::OP_NEG: begin
        res_n = lin2;
        ov_n  = lin_ov2;
      end
      v3a_pkg::OP_DIST: begin
        res_n = '0;
        ov_n  = lin_ov2;
      end
      v3a_pkg::OP_MUL,
      v3a_pkg::OP_SCALE: begin
        res_n = sh_sat;
        ov_n  = !sh_fit;
      end
      v3a_pkg::OP_CROSS: begin
        res_n = diff_sat;
        ov_n  = !diff_fit;
      end
      default: begin
        res_n = '0;
        ov_n  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vres <= res_n;
      vov  <= ov_n;
      dsh  <= sh0;
      sq   <= p0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/v3a_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module v3a_sqrt #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*W-1:0] n,
  output logic [W-1:0]   root
);

  logic [W+1:0]   rem_q  [W];
  logic [W-1:0]   root_q [W];
  logic [2*W-1:0] rad_q  [W];

  // one root bit per stage
  for (genvar s = 0; s < W; s++) begin : g_stage
    logic [W+1:0]   rem_i;
    logic [W-1:0]   root_i;
    logic [2*W-1:0] rad_i;
    logic [W+3:0]   trial, cand, diff;
    logic           ge;

    if (s == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = n;
    end else begin : g_next
      assign rem_i  = rem_q[s-1];
      assign root_i = root_q[s-1];
      assign rad_i  = rad_q[s-1];
    end

    assign trial = {rem_i, rad_i[2*W-1:2*W-2]};
    assign cand  = {2'b00, root_i, 2'b01};
    assign diff  = trial - cand;
    assign ge    = (trial >= cand);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s]  <= ge ? diff[W+1:0] : trial[W+1:0];
        root_q[s] <= {root_i[W-2:0], ge};
        rad_q[s]  <= {rad_i[2*W-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[W-1];

endmodule

`default_nettype wire

// File: rtl/core/v3a_div.sv
`timescale 1ns / 1ps
`default_nettype none

module v3a_div #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] num,
  input  logic signed [W-1:0] den,
  output logic signed [W-1:0] q,
  output v3a_pkg::flags_t     flags
);

  localparam int N = W + F;
  localparam logic signed [W-1:0] WMAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMINV = {1'b1, {(W-1){1'b0}}};

  logic [N-1:0] dq   [N+1];
  logic [W-1:0] rem  [N+1];
  logic [W-1:0] dd   [N+1];
  logic         neg  [N+1];
  logic         dz   [N+1];
  logic         npos [N+1];
  logic         nneg [N+1];

  logic [W-1:0] num_abs, den_abs;

  assign num_abs = num[W-1] ? (~num + 1'b1) : num;
  assign den_abs = den[W-1] ? (~den + 1'b1) : den;

  always_ff @(posedge clk) begin
    if (en) begin
      dq[0]   <= {num_abs, {F{1'b0}}};
      rem[0]  <= '0;
      dd[0]   <= den_abs;
      neg[0]  <= num[W-1] ^ den[W-1];
      dz[0]   <= (den == '0);
      npos[0] <= !num[W-1] && (num != '0);
      nneg[0] <= num[W-1];
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [W:0] trial, diff;
    logic       ge;

    assign trial = {rem[s], dq[s][N-1]};
    assign diff  = trial - {1'b0, dd[s]};
    assign ge    = (trial >= {1'b0, dd[s]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1]  <= ge ? diff[W-1:0] : trial[W-1:0];
        dq[s+1]   <= {dq[s][N-2:0], ge};
        dd[s+1]   <= dd[s];
        neg[s+1]  <= neg[s];
        dz[s+1]   <= dz[s];
        npos[s+1] <= npos[s];
        nneg[s+1] <= nneg[s];
      end
    end
  end

  logic [N-1:0]        quo;
  logic                big_pos, big_neg;
  logic signed [W-1:0] q_n;
  v3a_pkg::flags_t     flags_n;

  assign quo = dq[N];

  always_comb begin
    big_pos = |quo[N-1:W-1];
    big_neg = (|quo[N-1:W]) || (quo[W-1] && (|quo[W-2:0]));
    flags_n.dz = dz[N];
    flags_n.ov = 1'b0;
    if (dz[N]) begin
      q_n = npos[N] ? WMAXV : (nneg[N] ? WMINV : '0);
    end else if (neg[N]) begin
      q_n        = big_neg ? WMINV : (~quo[W-1:0] + 1'b1);
      flags_n.ov = big_neg;
    end else begin
      q_n        = big_pos ? WMAXV : quo[W-1:0];
      flags_n.ov = big_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q     <= q_n;
      flags <= flags_n;
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam int IDLE_LIMIT = 20000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  v3a_pkg::req_t req;
  logic rsp_valid;
  logic rsp_stall = 1'b1;
  v3a_pkg::rsp_t rsp;

  v3a_pkg::rsp_t pending_results[$];
  int sender_idle_pct;
  int receiver_stall_pct;
  bit hold_toggle;
  bit hold_seen;
  int hold_cycles;
  int quiet_cycles;
  int mismatches;
  int results_seen;
  int items_sent;

  vec3_fixed_point_alu DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint clamp_word(longint x, inout bit ov);
    if (x > WMAX) begin
      ov = 1'b1;
      return WMAX;
    end
    if (x < WMIN) begin
      ov = 1'b1;
      return WMIN;
    end
    return x;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> 16;
  endfunction

  function automatic longint fx_div(longint a, longint b, inout bit dz, inout bit ov);
    longint q;
    if (b == 0) begin
      dz = 1'b1;
      return a > 0 ? WMAX : (a < 0 ? WMIN : 64'sd0);
    end
    q = (a * 64'sd65536) / b;
    return clamp_word(q, ov);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic longint vec_length(longint x, longint y, longint z, inout bit ov);
    longint unsigned sum;
    longint root;
    sum = longint'(x * x) + longint'(y * y) + longint'(z * z);
    root = longint'(int_sqrt(sum));
    return clamp_word(root, ov);
  endfunction

  function automatic v3a_pkg::rsp_t compute_vec(v3a_pkg::req_t r);
    longint a[3];
    longint b[3];
    longint res[3];
    longint k;
    longint s;
    longint m;
    bit dz;
    bit ov;
    v3a_pkg::rsp_t o;
    a[0] = r.ax; a[1] = r.ay; a[2] = r.az;
    b[0] = r.bx; b[1] = r.by; b[2] = r.bz;
    k = r.scalar_in;
    res = '{0, 0, 0};
    s = 0;
    dz = 1'b0;
    ov = 1'b0;
    case (r.opcode)
      v3a_pkg::OP_ADD:
        for (int i = 0; i < 3; i++) res[i] = clamp_word(a[i] + b[i], ov);
      v3a_pkg::OP_SUB:
        for (int i = 0; i < 3; i++) res[i] = clamp_word(a[i] - b[i], ov);
      v3a_pkg::OP_NEG:
        for (int i = 0; i < 3; i++) res[i] = clamp_word(-a[i], ov);
      v3a_pkg::OP_MUL:
        for (int i = 0; i < 3; i++) res[i] = clamp_word(fx_mul(a[i], b[i]), ov);
      v3a_pkg::OP_SCALE:
        for (int i = 0; i < 3; i++) res[i] = clamp_word(fx_mul(a[i], k), ov);
      v3a_pkg::OP_DIV:
        for (int i = 0; i < 3; i++) res[i] = fx_div(a[i], b[i], dz, ov);
      v3a_pkg::OP_SDIV:
        for (int i = 0; i < 3; i++) res[i] = fx_div(a[i], k, dz, ov);
      v3a_pkg::OP_MAX: begin
        s = a[0];
        if (a[1] > s) s = a[1];
        if (a[2] > s) s = a[2];
      end
      v3a_pkg::OP_MAG: s = vec_length(a[0], a[1], a[2], ov);
      v3a_pkg::OP_NORM: begin
        m = vec_length(a[0], a[1], a[2], ov);
        if (m == 0) dz = 1'b1;
        else for (int i = 0; i < 3; i++) res[i] = fx_div(a[i], m, dz, ov);
      end
      v3a_pkg::OP_CROSS: begin
        res[0] = clamp_word(fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]), ov);
        res[1] = clamp_word(fx_mul(a[2], b[0]) - fx_mul(a[0], b[2]), ov);
        res[2] = clamp_word(fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]), ov);
      end
      v3a_pkg::OP_DOT:
        s = clamp_word(fx_mul(a[0], b[0]) + fx_mul(a[1], b[1]) + fx_mul(a[2], b[2]), ov);
      v3a_pkg::OP_DIST: begin
        for (int i = 0; i < 3; i++) res[i] = clamp_word(a[i] - b[i], ov);
        s = vec_length(res[0], res[1], res[2], ov);
        res = '{0, 0, 0};
      end
      default: ;
    endcase
    o.rx = 32'(res[0]);
    o.ry = 32'(res[1]);
    o.rz = 32'(res[2]);
    o.scalar_out = 32'(s);
    o.div_zero = dz;
    o.overflowed = ov;
    return o;
  endfunction

  function automatic v3a_pkg::req_t make_item(logic [3:0] op, int ax, int ay, int az,
                                              int bx, int by, int bz, int k);
    v3a_pkg::req_t r;
    r.opcode = op;
    r.ax = ax; r.ay = ay; r.az = az;
    r.bx = bx; r.by = by; r.bz = bz;
    r.scalar_in = k;
    return r;
  endfunction

  function automatic v3a_pkg::rsp_t make_result(int x, int y, int z, int s, bit dz, bit ov);
    v3a_pkg::rsp_t o;
    o.rx = x; o.ry = y; o.rz = z; o.scalar_out = s;
    o.div_zero = dz; o.overflowed = ov;
    return o;
  endfunction

  function automatic int rand_word();
    int v;
    case ($urandom_range(7))
      0: v = 32'h7fff_ffff;
      1: v = 32'h8000_0000;
      2: v = 0;
      3: v = $urandom_range(32'h3_ffff);
      4: v = -int'($urandom_range(32'h3_ffff));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_item(v3a_pkg::req_t r, v3a_pkg::rsp_t e);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    pending_results.push_back(e);
    items_sent++;
  endtask

  task automatic send_random(int count);
    v3a_pkg::req_t r;
    repeat (count) begin
      r = make_item(4'($urandom_range(15)), rand_word(), rand_word(), rand_word(),
                    rand_word(), rand_word(), rand_word(), rand_word());
      send_item(r, compute_vec(r));
    end
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // receiver side: stall pattern, result checking and watchdog
  always @(posedge clk) begin
    v3a_pkg::rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b1;
      quiet_cycles <= 0;
    end else begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", rsp);
        end else begin
          want = pending_results.pop_front();
          if (rsp.rx !== want.rx || rsp.ry !== want.ry || rsp.rz !== want.rz ||
              rsp.scalar_out !== want.scalar_out || rsp.div_zero !== want.div_zero ||
              rsp.overflowed !== want.overflowed) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p got %p", want, rsp);
          end
        end
      end
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_cycles = 300;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
    end
  end

  initial begin
    v3a_pkg::req_t dir_items[$];
    v3a_pkg::rsp_t dir_results[$];
    bit dir_typed[$];
    int wait_count;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    items_sent = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    dir_items = '{
      make_item(v3a_pkg::OP_ADD, 0, 0, 0, 0, 0, 0, 0),
      make_item(v3a_pkg::OP_ADD, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1,
                32'h7fffffff, -1, 0),
      make_item(v3a_pkg::OP_SUB, 32'h80000000, 32'h7fffffff, 5, 1, -1, 32'h80000000, 0),
      make_item(v3a_pkg::OP_NEG, 32'h80000000, 0, 32'h10000, 0, 0, 0, 0),
      make_item(v3a_pkg::OP_MUL, 32'h7fffffff, 32'h80000000, -32'h18000, 32'h7fffffff,
                32'h80000000, 32'h20000, 0),
      make_item(v3a_pkg::OP_SCALE, 32'h30000, -32'h8000, 32'h7fffffff, 0, 0, 0,
                -32'h28000),
      make_item(v3a_pkg::OP_DIV, 5, -5, 0, 0, 0, 0, 0),
      make_item(v3a_pkg::OP_DIV, 32'h7fffffff, 32'h10000, -32'h30000, 1, -32'h20000,
                32'h8000, 0),
      make_item(v3a_pkg::OP_SDIV, 32'h10000, 32'h80000000, 3, 0, 0, 0, -1),
      make_item(v3a_pkg::OP_SDIV, -7, 7, 0, 0, 0, 0, 0),
      make_item(v3a_pkg::OP_MAX, -3, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0),
      make_item(v3a_pkg::OP_MAX, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0),
      make_item(v3a_pkg::OP_MAG, 32'h30000, 32'h40000, 0, 0, 0, 0, 0),
      make_item(v3a_pkg::OP_MAG, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0),
      make_item(v3a_pkg::OP_NORM, 0, 0, 0, 0, 0, 0, 0),
      make_item(v3a_pkg::OP_NORM, 32'h30000, -32'h40000, 0, 0, 0, 0, 0),
      make_item(v3a_pkg::OP_NORM, 0, 0, 1, 0, 0, 0, 0),
      make_item(v3a_pkg::OP_CROSS, 32'h10000, 0, 0, 0, 32'h10000, 0, 0),
      make_item(v3a_pkg::OP_CROSS, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                32'h7fffffff, 32'h80000000, 0),
      make_item(v3a_pkg::OP_DOT, 32'h10000, 32'h20000, 32'h30000, 32'h40000, -32'h50000,
                32'h60000, 0),
      make_item(v3a_pkg::OP_DOT, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff, 32'h7fffffff, 0),
      make_item(v3a_pkg::OP_DIST, 32'h7fffffff, 0, 0, 32'h80000000, 0, 0, 0),
      make_item(4'd13, -1, -1, -1, -1, -1, -1, -1),
      make_item(4'd15, 32'h7fffffff, 1, 2, 3, 4, 5, 6)
    };
    dir_typed = '{1, 1, 0, 1, 0, 0, 1, 0, 0, 1, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1, 1};
    dir_results = '{
      make_result(0, 0, 0, 0, 0, 0),
      make_result(32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, 0, 1),
      '0,
      make_result(32'h7fffffff, 0, -32'h10000, 0, 0, 1),
      '0, '0,
      make_result(32'h7fffffff, 32'h80000000, 0, 0, 1, 0),
      '0, '0,
      make_result(32'h80000000, 32'h7fffffff, 0, 0, 1, 0),
      '0, '0, '0, '0,
      make_result(0, 0, 0, 0, 1, 0),
      '0, '0, '0, '0, '0, '0, '0,
      make_result(0, 0, 0, 0, 0, 0),
      make_result(0, 0, 0, 0, 0, 0)
    };
    foreach (dir_items[i])
      send_item(dir_items[i], dir_typed[i] ? dir_results[i] : compute_vec(dir_items[i]));
    drain_results();

    sender_idle_pct = 7;
    receiver_stall_pct = 84;
    send_random(450);
    drain_results();

    sender_idle_pct = 84;
    receiver_stall_pct = 7;
    send_random(450);
    drain_results();

    // long receiver hold-off so the pipeline fills and backs up the input
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_toggle = !hold_toggle;
    send_random(300);
    drain_results();
    send_random(300);
    drain_results();

    wait_count = 0;
    while (pending_results.size() != 0 && wait_count < 5000) begin
      @(posedge clk);
      wait_count++;
    end
    repeat (200) @(posedge clk);
    $display("sent %0d items over all opcodes incl. unused ones, saturation and zero divisors",
             items_sent);
    $display("checked %0d results under mixed idling and a long output hold-off, %0d bad",
             results_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/core/v3a_pkg.sv
rtl/core/v3a_delay.sv
rtl/core/v3a_lane.sv
rtl/core/v3a_sqrt.sv
rtl/core/v3a_div.sv
rtl/core/vec3_fixed_point_alu.sv
tb/sv/tb.sv
